>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the timing wheel.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent that must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/tlwt_pkg.sv
// Package with the request and response types and codes of the timing wheel.
package tlwt_pkg;

   localparam int TimerCountDef = 64;
   localparam int NearBitsDef   = 6;
   localparam int FarBitsDef    = 6;

   localparam int CmdW    = 2;
   localparam int IdW     = 6;
   localparam int TimeW   = 32;
   localparam int KindW   = 2;
   localparam int CountW  = 7;
   localparam int IdSpan  = 64;

   localparam logic [CmdW-1:0] CMD_ADD    = 2'd0;
   localparam logic [CmdW-1:0] CMD_MODIFY = 2'd1;
   localparam logic [CmdW-1:0] CMD_DELETE = 2'd2;
   localparam logic [CmdW-1:0] CMD_TICK   = 2'd3;

   localparam logic [KindW-1:0] KIND_ACK     = 2'd0;
   localparam logic [KindW-1:0] KIND_EXPIRED = 2'd1;
   localparam logic [KindW-1:0] KIND_NONE    = 2'd2;

   typedef struct packed {
      logic [CmdW-1:0]  command;
      logic [IdW-1:0]   timer_id;
      logic [TimeW-1:0] timeout;
   } req_type;

   typedef struct packed {
      logic [KindW-1:0]  result_kind;
      logic [IdW-1:0]    expired_id;
      logic [CountW-1:0] active_count;
      logic              last;
   } rsp_type;

endpackage

>>> hw/rtl/two_level_timing_wheel_core.sv
// Two-level timing wheel: timer table, command sequencer and expiry scan.
//
// Usage: requests arrive on req_valid/req_ready/req_data, responses leave on
// rsp_valid/rsp_ready/rsp_data. A request carries a command (add, modify,
// delete, tick), a timer number and a timeout.
// Add, modify and delete give one acknowledgement with the armed count. Delete
// and out-of-range requests go from idle straight to the acknowledge state; add and
// modify pass the arm state first. A tick walks the timer table one entry per cycle,
// unless held by a stalled response, through the shared slot compare and the single
// read port of the expiry memory, over the table depth (min(TIMER_COUNT, 64)), then flushes.
// Expired timers are reported one response each, in ascending timer number,
// the final one marked last; a tick that expires nothing gives one "none"
// response. req_ready is high only while the sequencer is idle, so one request
// is in work at a time.
// The response sits in an output register: a new request is accepted while the
// previous response still waits. If the receiver stalls, the scan holds at the
// next expiring entry until the pending response can move.
// Reset clears the armed flags, interval valid flags, tick counter and armed count
// at once; no clearing pass is needed.
module two_level_timing_wheel_core #(
   parameter int TIMER_COUNT = tlwt_pkg::TimerCountDef,
   parameter int NEAR_BITS   = tlwt_pkg::NearBitsDef,
   parameter int FAR_BITS    = tlwt_pkg::FarBitsDef
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tlwt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tlwt_pkg::rsp_type rsp_data
);
   import tlwt_pkg::*;
`include "assert_macros.svh"

   // Only timers whose number fits the timer_id field can ever be armed.
   localparam int Depth = (TIMER_COUNT < IdSpan) ? TIMER_COUNT : IdSpan;
   localparam int IdxW  = $clog2(Depth);
   localparam int ExpW  = TimeW + 1;
   localparam int FarPos = TimeW;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ARM   = 3'd1;
   localparam logic [2:0] ST_ACK   = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;
   localparam logic [2:0] ST_FLUSH = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [TimeW-1:0]  tick_ff, tick_in;
   logic [CountW-1:0] count_ff, count_in;
   logic [Depth-1:0]  armed_ff, armed_in;
   logic [Depth-1:0]  int_valid_ff;
   logic [CmdW-1:0]   cmd_ff, cmd_in;
   logic [IdW-1:0]    id_ff, id_in;
   logic [TimeW-1:0]  timeout_ff, timeout_in;
   logic [IdxW-1:0]   eval_idx_ff, eval_idx_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [IdW-1:0]    pend_id_ff, pend_id_in;
   logic [CountW-1:0] pend_cnt_ff, pend_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff;

   // Expiry memory: far-level flag above the 32-bit expiry tick.
   logic [ExpW-1:0]   exp_mem [Depth];
   logic [ExpW-1:0]   exp_rd_ff;
   logic [TimeW-1:0]  int_mem [Depth];
   logic [TimeW-1:0]  int_rd_ff;
   logic              int_ok_ff;

   logic              exp_wr_en, exp_rd_en, int_wr_en, int_rd_en;
   logic [IdxW-1:0]   exp_wr_addr, exp_rd_addr;
   logic [ExpW-1:0]   exp_wr_data;
   logic [IdxW-1:0]   req_idx, id_idx;
   logic              req_in_range;
   logic [TimeW-1:0]  interval;
   logic [TimeW-1:0]  add_operand, sum;
   logic              out_free, out_load;
   rsp_type           out_data;
   logic              near_wrap, cascade_hit, near_now, expire_hit, scan_stall;

   assign req_idx      = req_data.timer_id[IdxW-1:0];
   assign id_idx       = id_ff[IdxW-1:0];
   assign req_in_range = {1'b0, req_data.timer_id} < CountW'(Depth);

   // A timer never modified re-arms with interval zero.
   assign interval = (cmd_ff == CMD_ADD) ? (int_ok_ff ? int_rd_ff : '0) : timeout_ff;

   // Shared adder: expiry in the arm step, next tick otherwise.
   assign add_operand = (state_ff == ST_ARM) ? interval : TimeW'(1);
   assign sum         = tick_ff + add_operand;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Slot compare for the entry under scan; tick_ff already holds the new tick.
   assign near_wrap   = tick_ff[NEAR_BITS-1:0] == '0;
   assign cascade_hit = near_wrap && armed_ff[eval_idx_ff] && exp_rd_ff[FarPos] &&
                        (exp_rd_ff[NEAR_BITS +: FAR_BITS] == tick_ff[NEAR_BITS +: FAR_BITS]);
   assign near_now    = !exp_rd_ff[FarPos] || cascade_hit;
   assign expire_hit  = armed_ff[eval_idx_ff] && near_now &&
                        (exp_rd_ff[NEAR_BITS-1:0] == tick_ff[NEAR_BITS-1:0]);
   assign scan_stall  = expire_hit && pend_valid_ff && !out_free;

   always_comb begin
      state_in      = state_ff;
      tick_in       = tick_ff;
      count_in      = count_ff;
      armed_in      = armed_ff;
      cmd_in        = cmd_ff;
      id_in         = id_ff;
      timeout_in    = timeout_ff;
      eval_idx_in   = eval_idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      pend_cnt_in   = pend_cnt_ff;
      exp_wr_en     = 1'b0;
      exp_wr_addr   = eval_idx_ff;
      exp_wr_data   = {1'b0, exp_rd_ff[TimeW-1:0]};
      exp_rd_en     = 1'b0;
      exp_rd_addr   = '0;
      int_wr_en     = 1'b0;
      int_rd_en     = 1'b0;
      out_load      = 1'b0;
      out_data      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in     = req_data.command;
               id_in      = req_data.timer_id;
               timeout_in = req_data.timeout;
               if (req_data.command == CMD_TICK) begin
                  tick_in     = sum;
                  eval_idx_in = '0;
                  exp_rd_en   = 1'b1;
                  state_in    = ST_SCAN;
               end else if (!req_in_range) begin
                  state_in = ST_ACK;
               end else if (req_data.command == CMD_DELETE) begin
                  if (armed_ff[req_idx]) begin
                     armed_in[req_idx] = 1'b0;
                     count_in          = count_ff - 1'b1;
                  end
                  state_in = ST_ACK;
               end else begin
                  int_rd_en = 1'b1;
                  state_in  = ST_ARM;
               end
            end
         end
         ST_ARM: begin
            exp_wr_en   = 1'b1;
            exp_wr_addr = id_idx;
            exp_wr_data = {|interval[TimeW-1:NEAR_BITS], sum};
            int_wr_en   = 1'b1;
            if (!armed_ff[id_idx]) begin
               count_in = count_ff + 1'b1;
            end
            armed_in[id_idx] = 1'b1;
            state_in         = ST_ACK;
         end
         ST_ACK: begin
            if (out_free) begin
               out_load              = 1'b1;
               out_data.result_kind  = KIND_ACK;
               out_data.active_count = count_ff;
               out_data.last         = 1'b1;
               state_in              = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (!scan_stall) begin
               if (cascade_hit) begin
                  exp_wr_en = 1'b1;
               end
               if (expire_hit) begin
                  armed_in[eval_idx_ff] = 1'b0;
                  count_in              = count_ff - 1'b1;
                  // The previous expiry is not the last one: send it now.
                  if (pend_valid_ff) begin
                     out_load              = 1'b1;
                     out_data.result_kind  = KIND_EXPIRED;
                     out_data.expired_id   = pend_id_ff;
                     out_data.active_count = pend_cnt_ff;
                  end
                  pend_valid_in = 1'b1;
                  pend_id_in    = IdW'(eval_idx_ff);
                  pend_cnt_in   = count_ff - 1'b1;
               end
               if (eval_idx_ff == IdxW'(Depth - 1)) begin
                  state_in = ST_FLUSH;
               end else begin
                  eval_idx_in = eval_idx_ff + 1'b1;
                  exp_rd_en   = 1'b1;
                  exp_rd_addr = eval_idx_ff + 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               out_load      = 1'b1;
               out_data.last = 1'b1;
               if (pend_valid_ff) begin
                  out_data.result_kind  = KIND_EXPIRED;
                  out_data.expired_id   = pend_id_ff;
                  out_data.active_count = pend_cnt_ff;
               end else begin
                  out_data.result_kind  = KIND_NONE;
                  out_data.active_count = count_ff;
               end
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tick_ff       <= '0;
         count_ff      <= '0;
         armed_ff      <= '0;
         int_valid_ff  <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tick_ff       <= tick_in;
         count_ff      <= count_in;
         armed_ff      <= armed_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (int_wr_en) begin
            int_valid_ff[id_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      id_ff       <= id_in;
      timeout_ff  <= timeout_in;
      eval_idx_ff <= eval_idx_in;
      pend_id_ff  <= pend_id_in;
      pend_cnt_ff <= pend_cnt_in;
      if (out_load) begin
         rsp_data_ff <= out_data;
      end
   end

   always_ff @(posedge clock) begin
      if (exp_wr_en) begin
         exp_mem[exp_wr_addr] <= exp_wr_data;
      end
      if (exp_rd_en) begin
         exp_rd_ff <= exp_mem[exp_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (int_wr_en) begin
         int_mem[id_idx] <= interval;
      end
      if (int_rd_en) begin
         int_rd_ff <= int_mem[req_idx];
         int_ok_ff <= int_valid_ff[req_idx];
      end
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_ALWAYS(a_count_matches_armed, clock, reset, $countones(armed_ff) == count_ff, "armed count differs from armed flags")
   `ASSERT_IMPLIES(a_pending_disarmed, clock, reset, pend_valid_ff, !armed_ff[pend_id_ff[IdxW-1:0]], "pending expiry still armed")
   `ASSERT_IMPLIES(a_idle_no_pending, clock, reset, state_ff == ST_IDLE, !pend_valid_ff, "pending expiry left after tick")
   `ASSERT_NEXT(a_tick_starts_scan, clock, reset, req_valid && req_ready && req_data.command == CMD_TICK, state_ff == ST_SCAN && eval_idx_ff == '0, "tick did not start scan at entry zero")

endmodule
